/* rtl/core/lbp_pkg.sv */
package lbp_pkg;

  // geometry
  localparam int MaxWidth   = 1024;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int WidthCfgW  = 11;
  localparam int HeightCfgW = 13;
  localparam int RowW       = HeightCfgW + 1;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = HeightCfgW;

  // pixel and interpolation weights, Q0.WeightFracBits
  localparam int PixW           = 8;
  localparam int WeightFracBits = 12;
  localparam longint unsigned WOne    = 64'd1 << WeightFracBits;
  localparam longint unsigned WDiag   = WOne >> 1;
  localparam longint unsigned WSide   = (WOne * 64'd207106781 + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned WCentre = WOne - WDiag - 2 * WSide;
  localparam int SampW = PixW + WeightFracBits;

  localparam logic [PixW-1:0] BorderValue = PixW'(1);

  localparam int NeighbourCount = 8;
  localparam logic [7:0] NonUniformIndex = 8'(NeighbourCount * (NeighbourCount - 1) + 2);

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_UNIFORM_MODE = 2'd2;

  // request kinds
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic            func;
    logic [PixW-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last_of_frame;
  } out_item_t;

  typedef logic [PixW-1:0] pix_t;
  // [row][column], row 0 on top, column 0 on the left
  typedef pix_t [2:0][2:0] win_t;

  typedef logic [7:0] lut_t [256];

  function automatic logic is_uniform(logic [7:0] c);
    logic [7:0] x;
    int n;
    x = c ^ {c[6:0], c[7]};
    n = 0;
    for (int b = 0; b < 8; b++) begin
      n += int'(x[b]);
    end
    return n <= 2;
  endfunction

  function automatic lut_t build_uniform_lut();
    lut_t lut;
    int idx;
    idx = 0;
    for (int c = 0; c < 256; c++) begin
      if (is_uniform(8'(c))) begin
        lut[c] = 8'(idx);
        idx++;
      end else begin
        lut[c] = NonUniformIndex;
      end
    end
    return lut;
  endfunction

  localparam lut_t UniformLut = build_uniform_lut();

endpackage

/* rtl/core/lbp_ram.sv */
module lbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/lbp_code.sv */
module lbp_code import lbp_pkg::*; (
  input  win_t       win,
  input  logic       uniform,
  output logic [7:0] code
);

  // diagonal sample scaled by 2^F: corner, two sides, centre
  function automatic logic [SampW-1:0] diag(pix_t corner, pix_t s1, pix_t s2, pix_t ctr);
    return SampW'(corner) * SampW'(WDiag)
         + (SampW'(s1) + SampW'(s2)) * SampW'(WSide)
         + SampW'(ctr) * SampW'(WCentre);
  endfunction

  pix_t             ctr;
  logic [SampW-1:0] ctr_s;
  logic [7:0]       raw;

  assign ctr   = win[1][1];
  assign ctr_s = {ctr, {WeightFracBits{1'b0}}};

  always_comb begin
    raw[0] = win[2][1] > ctr;
    raw[1] = diag(win[2][0], win[2][1], win[1][0], ctr) > ctr_s;
    raw[2] = win[1][0] > ctr;
    raw[3] = diag(win[0][0], win[0][1], win[1][0], ctr) > ctr_s;
    raw[4] = win[0][1] > ctr;
    raw[5] = diag(win[0][2], win[0][1], win[1][2], ctr) > ctr_s;
    raw[6] = win[1][2] > ctr;
    raw[7] = diag(win[2][2], win[2][1], win[1][2], ctr) > ctr_s;
  end

  assign code = uniform ? UniformLut[raw] : raw;

endmodule

/* rtl/core/local_binary_pattern_stream.sv */
// channel | direction | handshake            | payload
// in_     | in        | in_valid / in_ready   | in_data   (func, pixel)
// out_    | out       | out_valid / out_ready | out_data  (code, last_of_frame)
// cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle sustained unless a result stalls; each one passes the line-store read
// register, then the window update, code and uniform lookup land in the result register.
// A result trails its pixel by one row plus one pixel of requests.
// Reset (synchronous, rst_n low) clears counters, window and valid flags; line stores
// hold no reset and are read only where the current frame has written them.
// A stalled result holds the stage behind it; in_ready drops only then.
module local_binary_pattern_stream import lbp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  typedef struct packed {
    logic            emit;
    logic            last;
    logic            col0;
    logic            top_ok;
    logic            mid_ok;
    logic [ColW-1:0] col;
    pix_t            bot;
  } stage_t;

  // configuration
  logic [WidthCfgW-1:0]  width_r;
  logic [HeightCfgW-1:0] height_r;
  logic                  uniform_r;
  logic [WidthCfgW-1:0]  w_eff;
  logic [HeightCfgW-1:0] h_eff;
  logic                  cfg_we;
  logic                  restart;

  // counters
  logic [ColW-1:0]       in_col_r, in_col_nxt;
  logic [RowW-1:0]       in_row_r, in_row_nxt;
  logic [ColW-1:0]       out_col_r, out_col_nxt;
  logic [HeightCfgW-1:0] out_row_r, out_row_nxt;

  // decode at acceptance
  logic   in_fire, drop, take;
  logic   in_wrap, out_wrap, emit, last;
  stage_t st_in;

  // stage
  logic   s1_valid_r, s1_valid_nxt;
  stage_t s1_r;
  logic   s1_fire;

  // line stores
  pix_t up_rdata, mid_rdata;
  logic fwd_r;
  pix_t fwd_up_r, fwd_mid_r;
  pix_t up_q, mid_q, top, mid;

  // window
  win_t win_r, win_nxt, win_shift, win_after;
  win_t win_border;

  logic [7:0] code;
  logic       out_valid_r;
  out_item_t  out_data_r;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WidthCfgW'(640);
      height_r  <= HeightCfgW'(480);
      uniform_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r   <= cfg_data[WidthCfgW-1:0];
        CFG_IMAGE_HEIGHT: height_r  <= cfg_data[HeightCfgW-1:0];
        CFG_UNIFORM_MODE: uniform_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = WidthCfgW'(1);
    end else if (width_r > WidthCfgW'(MaxWidth)) begin
      w_eff = WidthCfgW'(MaxWidth);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r == '0) ? HeightCfgW'(1) : height_r;
  end

  // ---------------------------------------------------------------- acceptance
  assign in_fire = in_valid && in_ready;
  assign drop    = (in_data.func == FUNC_DRAIN) && (in_row_r == '0) && (in_col_r == '0);
  assign take    = in_fire && !drop;

  always_comb begin
    in_wrap  = (WidthCfgW'(in_col_r) + WidthCfgW'(1)) >= w_eff;
    out_wrap = (WidthCfgW'(out_col_r) + WidthCfgW'(1)) >= w_eff;
    emit     = (in_row_r >= RowW'(2)) || ((in_row_r == RowW'(1)) && (in_col_r != '0));
    last     = emit && out_wrap && ((RowW'(out_row_r) + RowW'(1)) >= RowW'(h_eff));

    st_in.emit   = emit;
    st_in.last   = last;
    st_in.col0   = (in_col_r == '0);
    st_in.top_ok = in_row_r >= RowW'(2);
    st_in.mid_ok = in_row_r != '0;
    st_in.col    = in_col_r;
    st_in.bot    = (in_data.func == FUNC_PIXEL && in_row_r < RowW'(h_eff))
                   ? in_data.pixel : BorderValue;

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (restart || (take && last)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (take) begin
      in_col_nxt = in_wrap ? '0 : in_col_r + ColW'(1);
      in_row_nxt = in_row_r + RowW'(in_wrap);
      if (emit) begin
        out_col_nxt = out_wrap ? '0 : out_col_r + ColW'(1);
        out_row_nxt = out_row_r + HeightCfgW'(out_wrap);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // ---------------------------------------------------------------- stage
  assign s1_fire  = s1_valid_r && (!s1_r.emit || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (take) begin
        // the stage writes the column being read: take the new data instead
        fwd_r <= s1_fire && (s1_r.col == in_col_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r      <= st_in;
      fwd_up_r  <= mid;
      fwd_mid_r <= s1_r.bot;
    end
  end

  lbp_ram #(.Width(PixW), .Depth(MaxWidth)) u_upper (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_r.col),
    .wdata (mid),
    .re    (take),
    .raddr (in_col_r),
    .rdata (up_rdata)
  );

  lbp_ram #(.Width(PixW), .Depth(MaxWidth)) u_middle (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_r.col),
    .wdata (s1_r.bot),
    .re    (take),
    .raddr (in_col_r),
    .rdata (mid_rdata)
  );

  assign up_q  = fwd_r ? fwd_up_r : up_rdata;
  assign mid_q = fwd_r ? fwd_mid_r : mid_rdata;
  assign top   = s1_r.top_ok ? up_q : BorderValue;
  assign mid   = s1_r.mid_ok ? mid_q : BorderValue;

  // ---------------------------------------------------------------- window
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win_border[r][c] = BorderValue;
      end
    end

    for (int r = 0; r < 3; r++) begin
      win_shift[r][0] = win_r[r][1];
      win_shift[r][1] = win_r[r][2];
      win_shift[r][2] = BorderValue;
    end
    if (!s1_r.col0) begin
      win_shift[0][2] = top;
      win_shift[1][2] = mid;
      win_shift[2][2] = s1_r.bot;
    end

    win_after = win_shift;
    if (s1_r.col0) begin
      // new row: left of the first column is border
      win_after       = win_border;
      win_after[0][2] = top;
      win_after[1][2] = mid;
      win_after[2][2] = s1_r.bot;
    end

    win_nxt = win_r;
    if (restart) begin
      win_nxt = win_border;
    end else if (s1_fire) begin
      win_nxt = s1_r.last ? win_border : win_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= win_border;
    end else begin
      win_r <= win_nxt;
    end
  end

  lbp_code u_code (
    .win     (win_shift),
    .uniform (uniform_r),
    .code    (code)
  );

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_r.emit) begin
      out_data_r.code          <= code;
      out_data_r.last_of_frame <= s1_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/lbp_checker.sv */
module lbp_checker import lbp_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input out_item_t           out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [CfgIdxW-1:0]  cfg_index,
  input logic [CfgDataW-1:0] cfg_data
);

  logic mode_r;

  // track the mode as written on the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready && cfg_index == CFG_UNIFORM_MODE) begin
      mode_r <= cfg_data[0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_in_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  a_uniform_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r |-> out_data.code <= NonUniformIndex)
    else $error("uniform index out of range");

  a_frame_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_of_frame |=> !out_valid)
    else $error("result straight after end of frame");

endmodule

bind local_binary_pattern_stream lbp_checker u_lbp_checker (.*);

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbp_pkg::*;

  localparam int unsigned MAX_COLS     = 1024;
  localparam int unsigned FRAC_BITS    = 12;
  localparam longint unsigned W_ONE    = 64'd1 << FRAC_BITS;
  localparam longint unsigned W_DIAG   = W_ONE / 2;
  localparam longint unsigned W_SIDE   = (W_ONE * 64'd207106781 + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned W_CENTRE = W_ONE - W_DIAG - 2 * W_SIDE;
  localparam logic [7:0] BORDER        = 8'd1;
  localparam logic [7:0] NON_UNIFORM   = 8'd58;
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned CALM_ITEMS   = 60;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned SETTLE       = 6;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned MAX_REPORTS  = 100;

  // Tracks window, line stores and frame position; queues the codes still due out.
  class lbp_scoreboard;
    int unsigned width_reg, height_reg;
    bit uniform_on;
    logic [7:0] upper_row [MAX_COLS];
    logic [7:0] middle_row [MAX_COLS];
    logic [7:0] win [3][3];
    logic [7:0] uniform_of [256];
    int unsigned in_col, in_row, out_col, out_row;
    int unsigned accepted_items, errors;
    out_item_t due_q [$];

    function new();
      int idx;
      idx = 0;
      for (int c = 0; c < 256; c++) begin
        if (transitions(8'(c)) <= 2) begin
          uniform_of[c] = 8'(idx);
          idx++;
        end else begin
          uniform_of[c] = NON_UNIFORM;
        end
      end
      width_reg = 640;
      height_reg = 480;
      uniform_on = 1'b0;
      accepted_items = 0;
      errors = 0;
      restart();
    endfunction

    function int transitions(logic [7:0] c);
      int n;
      n = 0;
      for (int b = 0; b < 8; b++) begin
        if (c[b] != c[(b + 1) % 8]) n++;
      end
      return n;
    endfunction

    function void restart();
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) win[r][c] = BORDER;
      end
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH: begin
          width_reg = data[WidthCfgW-1:0];
          restart();
        end
        CFG_IMAGE_HEIGHT: begin
          height_reg = data;
          restart();
        end
        CFG_UNIFORM_MODE: uniform_on = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_COLS) return MAX_COLS;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int unsigned frame_size();
      return eff_w() * eff_h();
    endfunction

    function int unsigned position();
      return in_row * eff_w() + in_col;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function bit diag_above(logic [7:0] corner, logic [7:0] s1, logic [7:0] s2,
                            logic [7:0] ctr);
      longint unsigned acc;
      acc = W_DIAG * longint'(corner) + W_SIDE * (longint'(s1) + longint'(s2))
            + W_CENTRE * longint'(ctr);
      return acc > (longint'(ctr) << FRAC_BITS);
    endfunction

    function logic [7:0] pattern();
      logic [7:0] ctr, code;
      ctr = win[1][1];
      code[0] = win[2][1] > ctr;
      code[1] = diag_above(win[2][0], win[2][1], win[1][0], ctr);
      code[2] = win[1][0] > ctr;
      code[3] = diag_above(win[0][0], win[0][1], win[1][0], ctr);
      code[4] = win[0][1] > ctr;
      code[5] = diag_above(win[0][2], win[0][1], win[1][2], ctr);
      code[6] = win[1][2] > ctr;
      code[7] = diag_above(win[2][2], win[2][1], win[1][2], ctr);
      return code;
    endfunction

    function void shift_column(logic [7:0] t, logic [7:0] m, logic [7:0] b);
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = t;
      win[1][2] = m;
      win[2][2] = b;
    endfunction

    function void note_request(logic f, logic [7:0] p);
      int unsigned w, k, ic;
      logic [7:0] top, mid, bot, code;
      bit emit;
      out_item_t due;
      w = eff_w();
      k = position();
      ic = in_col % MAX_COLS;
      // a drain with nothing of the frame taken yet is ignored
      if (f == FUNC_DRAIN && k == 0) return;
      accepted_items++;
      bot = (f == FUNC_PIXEL && k < frame_size()) ? p : BORDER;
      top = (in_row >= 2) ? upper_row[ic] : BORDER;
      mid = (in_row >= 1) ? middle_row[ic] : BORDER;
      emit = k >= w + 1;
      code = '0;
      if (ic == 0) begin
        // close the previous row against the right border, then start afresh
        shift_column(BORDER, BORDER, BORDER);
        if (emit) code = pattern();
        for (int r = 0; r < 3; r++) begin
          win[r][0] = BORDER;
          win[r][1] = BORDER;
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = bot;
      end else begin
        shift_column(top, mid, bot);
        if (emit) code = pattern();
      end
      upper_row[ic] = mid;
      middle_row[ic] = bot;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (!emit) return;
      due.code = uniform_on ? uniform_of[code] : code;
      due.last_of_frame = (out_row + 1 >= eff_h()) && (out_col + 1 >= w);
      due_q.push_back(due);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      if (due.last_of_frame) restart();
    endfunction

    function void flag(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t due;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with none expected: expected nothing, actual code %0d last %0b",
                   $time, got.code, got.last_of_frame);
        return;
      end
      due = due_q.pop_front();
      if (got.code !== due.code) flag("code", due.code, got.code);
      if (got.last_of_frame !== due.last_of_frame)
        flag("last_of_frame", due.last_of_frame, got.last_of_frame);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  lbp_scoreboard sb;
  bit calm = 1'b0;
  bit sender_gaps = 1'b0;
  bit hold_req = 1'b0;
  int unsigned pix_mode = 0;
  logic [7:0] pix_base = 8'd0;
  int unsigned quiet_cycles = 0;

  local_binary_pattern_stream DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] pick_pixel(int unsigned col, int unsigned row);
    case (pix_mode)
      0: return 8'($urandom_range(0, 255));
      1: return 8'(pix_base + col * 9 + row * 23 + $urandom_range(0, 2));
      2: begin
        case ($urandom_range(0, 4))
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd2;
          3: return 8'd254;
          default: return 8'd255;
        endcase
      end
      default: return 8'(pix_base + $urandom_range(0, 1));
    endcase
  endfunction

  // Entered and left at a falling edge; valid stays up between back-to-back requests.
  task automatic send_item(input logic f, input logic [7:0] p);
    if (!calm && sender_gaps && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= in_item_t'{func: f, pixel: p};
    do @(posedge clk); while (!in_ready);
    sb.note_request(f, p);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Hold the sender until every result is out and the pipe has settled, then reprogram.
  task automatic configure(input logic [CfgDataW-1:0] wd, input logic [CfgDataW-1:0] hd,
                           input logic u, input bit stray);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (stray) write_reg(CfgIdxW'(3), CfgDataW'($urandom));
    write_reg(CFG_UNIFORM_MODE, CfgDataW'({12'($urandom), u}));
    write_reg(CFG_IMAGE_WIDTH, wd);
    write_reg(CFG_IMAGE_HEIGHT, hd);
    cfg_valid <= 1'b0;
  endtask

  // Drain until the last result of the frame has been requested; now and then a surplus pixel.
  task automatic flush();
    while (sb.position() != 0) begin
      if ($urandom_range(0, 9) == 0) send_item(FUNC_PIXEL, 8'($urandom));
      else send_item(FUNC_DRAIN, 8'($urandom));
    end
  endtask

  // stop_after of zero runs the frame to its end; otherwise abandon it after that many requests
  task automatic run_frame(input int unsigned stop_after);
    int unsigned n;
    n = 0;
    while (sb.position() < sb.frame_size() && (stop_after == 0 || n < stop_after)) begin
      if ($urandom_range(0, 99) < 3) send_item(FUNC_DRAIN, 8'($urandom));
      else send_item(FUNC_PIXEL, pick_pixel(sb.in_col, sb.in_row));
      n++;
    end
    if (stop_after == 0) flush();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // result side: short stalls, ready stretches, and one long hold-off on request
  initial begin
    int unsigned span;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        span = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 12) begin
        out_ready <= 1'b0;
        span = $urandom_range(1, 19);
      end else begin
        out_ready <= 1'b1;
        span = $urandom_range(1, 30);
      end
      repeat (span) @(negedge clk);
    end
  end

  initial begin
    int unsigned start_count, r;
    logic [CfgDataW-1:0] wd, hd;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(FUNC_DRAIN, 8'hA5);

    // 3x3: extremes, ties with the border, a surplus pixel while flushing
    configure(13'd3, 13'd3, 1'b0, 1'b1);
    send_item(FUNC_PIXEL, 8'h00);
    send_item(FUNC_PIXEL, 8'hFF);
    send_item(FUNC_PIXEL, 8'h01);
    send_item(FUNC_PIXEL, 8'hFF);
    send_item(FUNC_PIXEL, 8'h01);
    send_item(FUNC_PIXEL, 8'hFF);
    send_item(FUNC_PIXEL, 8'h02);
    send_item(FUNC_PIXEL, 8'hFE);
    send_item(FUNC_PIXEL, 8'h01);
    send_item(FUNC_DRAIN, 8'h00);
    send_item(FUNC_PIXEL, 8'h7E);
    flush();

    // zero sizes act as one; high width bits are dropped
    configure(13'h1800, 13'h0000, 1'b1, 1'b0);
    send_item(FUNC_PIXEL, 8'h00);
    flush();

    // drain in the middle of a frame stands for a border-valued pixel
    configure(13'd2, 13'd2, 1'b1, 1'b0);
    send_item(FUNC_PIXEL, 8'h80);
    send_item(FUNC_DRAIN, 8'h55);
    send_item(FUNC_PIXEL, 8'h40);
    send_item(FUNC_PIXEL, 8'h01);
    flush();

    // widest row (clamped) and tallest frame, abandoned just past the first row
    configure(13'h07FF, 13'h1FFF, 1'b1, 1'b0);
    pix_mode = 0;
    sender_gaps = 1'b1;
    run_frame(1030);

    // fill the block while the result side holds off
    configure(13'd8, 13'd8, 1'b0, 1'b0);
    sender_gaps = 1'b0;
    pix_mode = 1;
    pix_base = 8'($urandom);
    hold_req = 1'b1;
    run_frame(0);

    start_count = sb.accepted_items;
    while (sb.accepted_items - start_count < RANDOM_ITEMS) begin
      calm = (sb.accepted_items - start_count) >= RANDOM_ITEMS - CALM_ITEMS;
      r = $urandom_range(0, 99);
      if (r < 5) wd = 13'd0;
      else if (r < 10) wd = 13'd1;
      else if (r < 15) wd = 13'h1800 | 13'($urandom_range(1, 6));
      else if (r < 22) wd = 13'($urandom_range(13, 64));
      else wd = 13'($urandom_range(2, 12));
      r = $urandom_range(0, 99);
      if (r < 6) hd = 13'd0;
      else if (r < 12) hd = 13'd1;
      else if (wd >= 13 && wd <= 64) hd = 13'($urandom_range(1, 2));
      else hd = 13'($urandom_range(2, 8));
      configure(wd, hd, 1'($urandom_range(0, 1)), $urandom_range(0, 6) == 0);
      pix_mode = $urandom_range(0, 3);
      pix_base = 8'($urandom);
      sender_gaps = $urandom_range(0, 9) >= 3;
      run_frame(($urandom_range(0, 9) == 0) ? $urandom_range(1, sb.frame_size()) : 0);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
